// ===== rtl/core/weekly_slot_schedule_table_macros.svh =====
// Assertion macros for the weekly slot schedule table.
// Included by the top level; no other dependencies.
`ifndef WEEKLY_SLOT_SCHEDULE_TABLE_MACROS_SVH
`define WEEKLY_SLOT_SCHEDULE_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
`define WSST_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define WSST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define WSST_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define WSST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/wsst_pkg.sv =====
// Shared constants and types for the weekly slot schedule table.
// No dependencies.
`timescale 1ns / 1ps
package wsst_pkg;
   localparam int OP_W                  = 3;
   localparam int DAY_W                 = 3;
   localparam int HOUR_W                = 5;
   localparam int MINUTE_W              = 6;
   localparam int ENTRY_W               = 8;
   localparam int EVERY_DAY_BIT         = 7;
   localparam int LAST_DAY              = 6;
   localparam int LAST_HOUR             = 23;
   localparam int HOURS_PER_DAY         = 24;
   localparam int DAYS_PER_WEEK         = 7;
   localparam int MAX_MINUTE            = 59;
   localparam int MINUTES_PER_HOUR      = 60;
   localparam int DEFAULT_BINS_PER_HOUR = 4;
   localparam int REQ_DATA_W            = 16;
   localparam int RSP_DATA_W            = 16;

   typedef enum logic [OP_W-1:0] {
      OP_SET_DAY       = 3'd0,
      OP_SET_EVERY_DAY = 3'd1,
      OP_CLEAR_DAY     = 3'd2,
      OP_FIND_NEXT     = 3'd3,
      OP_CLEAR_ALL     = 3'd4
   } op_type;
endpackage

// ===== rtl/core/wsst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module wsst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/weekly_slot_schedule_table.sv =====
// Weekly slot schedule table: top level with sequencer and scan logic.
// Depends on wsst_pkg, wsst_ram and weekly_slot_schedule_table_macros.svh.
//
// Usage:
// The req channel carries one operation per item: req_tuser holds the op code,
// req_tdata the weekday, hour and minute. Only a find produces an item on the
// rsp channel: rsp_tuser holds the found flag, rsp_tdata the weekday, hour
// and start minute of the next scheduled slot (all zero when none exists).
// Set day, set every day and clear day read the entry, then write it back.
// A find scans one slot per cycle through the single read port of the table,
// up to one week of slots, and stops early when a scheduled slot is hit; the
// result is then loaded into the output register. The block takes one item
// at a time; req_tready is high only while it is idle.
// Reset clears per-entry valid bits at once, so the whole table reads as
// empty in the first cycle after reset with no clearing pass.
// The result waits in an output register while the receiver stalls; new
// items are still taken, and a later find holds until that register frees.
`timescale 1ns / 1ps
`include "weekly_slot_schedule_table_macros.svh"
module weekly_slot_schedule_table #(
   parameter int BINS_PER_HOUR = wsst_pkg::DEFAULT_BINS_PER_HOUR
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // Bits: weekday [2:0], hour [7:3], minute [13:8], zero [15:14].
   input  logic [wsst_pkg::REQ_DATA_W-1:0] req_tdata,
   // Bits: op [2:0].
   input  logic [wsst_pkg::OP_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // Bits: next_weekday [2:0], next_hour [7:3], next_minute [13:8], zero [15:14].
   output logic [wsst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Bits: found [0].
   output logic [0:0]                      rsp_tuser
);
   import wsst_pkg::*;

   localparam int MINUTES_PER_SLOT = MINUTES_PER_HOUR / BINS_PER_HOUR;
   localparam int DAY_SLOTS        = HOURS_PER_DAY * BINS_PER_HOUR;
   localparam int SCAN_LEN         = DAY_SLOTS * DAYS_PER_WEEK;
   localparam int POS_W            = $clog2(DAY_SLOTS);
   localparam int SLOT_W           = (BINS_PER_HOUR > 1) ? $clog2(BINS_PER_HOUR) : 1;
   localparam int CNT_W            = $clog2(SCAN_LEN + 1);

   typedef struct packed {
      logic [DAY_W-1:0]  day;
      logic [HOUR_W-1:0] hour;
      logic [SLOT_W-1:0] slot;
      logic [POS_W-1:0]  pos;
   } spot_type;

   typedef struct packed {
      logic                found;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
   } result_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MODIFY,
      S_SCAN,
      S_RESULT
   } state_type;

   function automatic spot_type next_spot(spot_type s);
      spot_type r;
      r = s;
      if (s.slot == SLOT_W'(BINS_PER_HOUR - 1)) begin
         r.slot = '0;
         if (s.hour == HOUR_W'(LAST_HOUR)) begin
            r.hour = '0;
            r.pos  = '0;
            r.day  = (s.day == DAY_W'(LAST_DAY)) ? '0 : s.day + 1'b1;
         end else begin
            r.hour = s.hour + 1'b1;
            r.pos  = s.pos + 1'b1;
         end
      end else begin
         r.slot = s.slot + 1'b1;
         r.pos  = s.pos + 1'b1;
      end
      return r;
   endfunction

   state_type           state_ff;
   logic [DAY_SLOTS-1:0] valid_ff;
   logic                rd_valid_ff;
   op_type              mod_op_ff;
   logic [DAY_W-1:0]    mod_day_ff;
   logic [POS_W-1:0]    mod_ix_ff;
   spot_type            scan_ff;
   spot_type            chk_ff;
   logic                pending_ff;
   logic [CNT_W-1:0]    issue_cnt_ff;
   result_type          res_ff;
   result_type          rsp_ff;
   logic                rsp_tvalid_ff;

   logic                accept;
   logic [DAY_W-1:0]    in_day;
   logic [HOUR_W-1:0]   in_hour;
   logic [MINUTE_W-1:0] in_minute;
   logic [SLOT_W-1:0]   in_bin;
   logic [POS_W-1:0]    in_ix;
   spot_type            start_spot;
   logic [POS_W-1:0]    rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;
   logic [ENTRY_W-1:0]  entry;
   logic [ENTRY_W-1:0]  mod_entry;
   logic                wr_en;
   logic                hit;
   logic                rsp_free;

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      in_day    = (req_tdata[2:0] > DAY_W'(LAST_DAY)) ? DAY_W'(LAST_DAY) : req_tdata[2:0];
      in_hour   = (req_tdata[7:3] > HOUR_W'(LAST_HOUR)) ? HOUR_W'(LAST_HOUR) : req_tdata[7:3];
      in_minute = (req_tdata[13:8] > MINUTE_W'(MAX_MINUTE)) ? MINUTE_W'(MAX_MINUTE)
                                                            : req_tdata[13:8];
      in_bin = '0;
      for (int k = 1; k < BINS_PER_HOUR; k++) begin
         if (in_minute >= MINUTE_W'(k * MINUTES_PER_SLOT)) begin
            in_bin = SLOT_W'(k);
         end
      end
      in_ix      = POS_W'(in_hour * BINS_PER_HOUR) + POS_W'(in_bin);
      start_spot = next_spot('{day: in_day, hour: in_hour, slot: in_bin, pos: in_ix});
   end

   assign rd_addr = (state_ff == S_SCAN) ? scan_ff.pos : in_ix;
   assign entry   = rd_valid_ff ? ram_rd_data : '0;
   assign hit     = pending_ff && (entry[chk_ff.day] || entry[EVERY_DAY_BIT]);
   assign wr_en   = (state_ff == S_MODIFY);

   always_comb begin
      logic [ENTRY_W-1:0] day_mask;
      day_mask  = ENTRY_W'(1) << mod_day_ff;
      mod_entry = entry;
      unique case (mod_op_ff)
         OP_SET_DAY: begin
            mod_entry = entry | day_mask;
            if (&mod_entry[EVERY_DAY_BIT-1:0]) begin
               mod_entry[EVERY_DAY_BIT] = 1'b1;
            end
         end
         OP_SET_EVERY_DAY: begin
            mod_entry[EVERY_DAY_BIT] = 1'b1;
         end
         OP_CLEAR_DAY: begin
            mod_entry = entry & ~day_mask;
            mod_entry[EVERY_DAY_BIT] = 1'b0;
         end
         default: begin
            mod_entry = entry;
         end
      endcase
   end

   wsst_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DAY_SLOTS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(mod_ix_ff),
      .wr_data(mod_entry),
      .rd_addr(rd_addr),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[rd_addr];
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         pending_ff    <= 1'b0;
         issue_cnt_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (state_ff == S_RESULT && rsp_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  mod_op_ff  <= op_type'(req_tuser);
                  mod_day_ff <= in_day;
                  mod_ix_ff  <= in_ix;
                  unique case (req_tuser)
                     OP_SET_DAY, OP_SET_EVERY_DAY, OP_CLEAR_DAY: begin
                        state_ff <= S_MODIFY;
                     end
                     OP_FIND_NEXT: begin
                        scan_ff      <= start_spot;
                        issue_cnt_ff <= '0;
                        pending_ff   <= 1'b0;
                        state_ff     <= S_SCAN;
                     end
                     OP_CLEAR_ALL: begin
                        valid_ff <= '0;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_MODIFY: begin
               valid_ff[mod_ix_ff] <= 1'b1;
               state_ff            <= S_IDLE;
            end
            S_SCAN: begin
               if (issue_cnt_ff != CNT_W'(SCAN_LEN)) begin
                  chk_ff       <= scan_ff;
                  scan_ff      <= next_spot(scan_ff);
                  issue_cnt_ff <= issue_cnt_ff + 1'b1;
                  pending_ff   <= 1'b1;
               end else begin
                  pending_ff <= 1'b0;
               end
               if (hit) begin
                  res_ff.found  <= 1'b1;
                  res_ff.day    <= chk_ff.day;
                  res_ff.hour   <= chk_ff.hour;
                  res_ff.minute <= MINUTE_W'(chk_ff.slot * MINUTES_PER_SLOT);
                  state_ff      <= S_RESULT;
               end else if (pending_ff && issue_cnt_ff == CNT_W'(SCAN_LEN)) begin
                  res_ff   <= '0;
                  state_ff <= S_RESULT;
               end
            end
            S_RESULT: begin
               if (rsp_free) begin
                  rsp_ff   <= res_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.minute, rsp_ff.hour, rsp_ff.day};
   assign rsp_tuser  = rsp_ff.found;

   `WSST_ASSERT_IMPL(a_rsp_from_result, clock, reset, $rose(rsp_tvalid_ff), $past(state_ff == S_RESULT), "result item raised outside the result step")
   `WSST_ASSERT_IMPL(a_scan_bound, clock, reset, state_ff == S_SCAN, issue_cnt_ff <= CNT_W'(SCAN_LEN), "scan issued more reads than one week of slots")
   `WSST_ASSERT_IMPL(a_not_found_zero, clock, reset, rsp_tvalid_ff && !rsp_ff.found, rsp_tdata == '0, "result without a hit carries nonzero fields")
   `WSST_ASSERT_NEXT(a_modify_returns, clock, reset, state_ff == S_MODIFY, state_ff == S_IDLE, "table update did not finish in one cycle")
endmodule

// ===== test/slot_schedule_checker.sv =====
`timescale 1ns / 1ps
// Checker for the weekly slot schedule table: watches both streams, keeps its own
// copy of the slot table, and compares every find result with its own answer.
// Depends on wsst_pkg.
module slot_schedule_checker #(
   parameter int BINS_PER_HOUR = wsst_pkg::DEFAULT_BINS_PER_HOUR
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // Bits: weekday [2:0], hour [7:3], minute [13:8], zero [15:14].
   input  logic [wsst_pkg::REQ_DATA_W-1:0] req_tdata,
   // Bits: op [2:0].
   input  logic [wsst_pkg::OP_W-1:0]       req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // Bits: next_weekday [2:0], next_hour [7:3], next_minute [13:8], zero [15:14].
   input  logic [wsst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Bits: found [0].
   input  logic [0:0]                      rsp_tuser,
   output int                              mismatch_count,
   output int                              pending_count
);
   import wsst_pkg::*;

   localparam int MINUTES_PER_SLOT = MINUTES_PER_HOUR / BINS_PER_HOUR;
   localparam int DAY_SLOTS        = HOURS_PER_DAY * BINS_PER_HOUR;
   localparam int WEEK_SLOTS       = DAY_SLOTS * DAYS_PER_WEEK;
   localparam int HOUR_LSB         = DAY_W;
   localparam int MINUTE_LSB       = DAY_W + HOUR_W;
   localparam int REPORT_LIMIT     = 10;

   typedef struct packed {
      logic                found;
      logic [DAY_W-1:0]    weekday;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
   } slot_hit_type;

   logic [ENTRY_W-1:0] slot_table [DAY_SLOTS];
   slot_hit_type       expected_hits [$];
   int                 errors;

   function automatic void apply_schedule_op(
      input  logic [OP_W-1:0]     op,
      input  logic [DAY_W-1:0]    weekday_in,
      input  logic [HOUR_W-1:0]   hour_in,
      input  logic [MINUTE_W-1:0] minute_in,
      output logic                has_hit,
      output slot_hit_type        hit
   );
      int                 day;
      int                 hr;
      int                 mn;
      int                 bin;
      int                 ix;
      int                 pos;
      int                 scanned;
      logic               hit_found;
      logic [ENTRY_W-1:0] day_bit;
      day = (weekday_in > LAST_DAY) ? LAST_DAY : int'(weekday_in);
      hr  = (hour_in > LAST_HOUR) ? LAST_HOUR : int'(hour_in);
      mn  = (minute_in > MAX_MINUTE) ? MAX_MINUTE : int'(minute_in);
      bin = mn / MINUTES_PER_SLOT;
      if (bin > BINS_PER_HOUR - 1) begin
         bin = BINS_PER_HOUR - 1;
      end
      ix = hr * BINS_PER_HOUR + bin;
      day_bit = '0;
      day_bit[day] = 1'b1;
      has_hit = 1'b0;
      hit = '0;
      case (op)
         OP_SET_DAY: begin
            slot_table[ix] = slot_table[ix] | day_bit;
            if (&slot_table[ix][LAST_DAY:0]) begin
               slot_table[ix][EVERY_DAY_BIT] = 1'b1;
            end
         end
         OP_SET_EVERY_DAY: begin
            slot_table[ix][EVERY_DAY_BIT] = 1'b1;
         end
         OP_CLEAR_DAY: begin
            slot_table[ix] = slot_table[ix] & ~day_bit;
            slot_table[ix][EVERY_DAY_BIT] = 1'b0;
         end
         OP_FIND_NEXT: begin
            pos = ix + 1;
            if (pos >= DAY_SLOTS) begin
               pos = 0;
               day = (day + 1) % DAYS_PER_WEEK;
            end
            scanned = 0;
            hit_found = 1'b0;
            while (!hit_found && scanned < WEEK_SLOTS) begin
               if (slot_table[pos][day] || slot_table[pos][EVERY_DAY_BIT]) begin
                  hit_found = 1'b1;
               end else begin
                  pos++;
                  if (pos >= DAY_SLOTS) begin
                     pos = 0;
                     day = (day + 1) % DAYS_PER_WEEK;
                  end
                  scanned++;
               end
            end
            has_hit = 1'b1;
            if (hit_found) begin
               hit.found   = 1'b1;
               hit.weekday = day[DAY_W-1:0];
               hit.hour    = HOUR_W'(pos / BINS_PER_HOUR);
               hit.minute  = MINUTE_W'((pos % BINS_PER_HOUR) * MINUTES_PER_SLOT);
            end
         end
         OP_CLEAR_ALL: begin
            for (int i = 0; i < DAY_SLOTS; i++) begin
               slot_table[i] = '0;
            end
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin : watch_streams
      slot_hit_type seen;
      slot_hit_type want;
      slot_hit_type predicted;
      logic         has_hit;
      if (reset) begin
         for (int i = 0; i < DAY_SLOTS; i++) begin
            slot_table[i] = '0;
         end
         expected_hits.delete();
         errors = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.found   = rsp_tuser[0];
            seen.weekday = rsp_tdata[DAY_W-1:0];
            seen.hour    = rsp_tdata[HOUR_LSB +: HOUR_W];
            seen.minute  = rsp_tdata[MINUTE_LSB +: MINUTE_W];
            if (expected_hits.size() == 0) begin
               if (errors < REPORT_LIMIT) begin
                  $display("%0t: unexpected result found=%0d day=%0d hour=%0d minute=%0d",
                           $time, seen.found, seen.weekday, seen.hour, seen.minute);
               end
               errors++;
            end else begin
               want = expected_hits.pop_front();
               if (seen.found !== want.found || seen.weekday !== want.weekday ||
                   seen.hour !== want.hour || seen.minute !== want.minute) begin
                  if (errors < REPORT_LIMIT) begin
                     $display("%0t: mismatch expected found=%0d day=%0d hour=%0d minute=%0d",
                              $time, want.found, want.weekday, want.hour, want.minute);
                     $display("%0t:          actual   found=%0d day=%0d hour=%0d minute=%0d",
                              $time, seen.found, seen.weekday, seen.hour, seen.minute);
                  end
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_schedule_op(req_tuser, req_tdata[DAY_W-1:0], req_tdata[HOUR_LSB +: HOUR_W],
                              req_tdata[MINUTE_LSB +: MINUTE_W], has_hit, predicted);
            if (has_hit) begin
               expected_hits.push_back(predicted);
            end
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_hits.size();
   end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the weekly slot schedule table testbench: clock, reset, request and
// response stimulus, and the verdict. Depends on wsst_pkg, the block and
// slot_schedule_checker.
module testbench;
   import wsst_pkg::*;

   localparam int BINS_PER_HOUR   = DEFAULT_BINS_PER_HOUR;
   localparam int RANDOM_ITEMS    = 850;
   localparam int TAIL_ITEMS      = 100;
   localparam int HOLD_START      = 2500;
   localparam int HOLD_CYCLES     = 1500;
   localparam int SCAN_CYCLES     = DAYS_PER_WEEK * HOURS_PER_DAY * BINS_PER_HOUR + 3;
   localparam int DRAIN_CYCLES    = SCAN_CYCLES + 20;
   localparam int CYCLE_LIMIT     = 4 * (RANDOM_ITEMS + 50) * (SCAN_CYCLES + 20)
                                    + 4 * HOLD_CYCLES;
   localparam int OP_CODE_MAX     = (1 << OP_W) - 1;
   localparam int DAY_CODE_MAX    = (1 << DAY_W) - 1;
   localparam int HOUR_CODE_MAX   = (1 << HOUR_W) - 1;
   localparam int MINUTE_CODE_MAX = (1 << MINUTE_W) - 1;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   bit                    quiet_tail = 1'b0;
   int                    mismatch_count;
   int                    pending_count;
   int                    cycle_count;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   weekly_slot_schedule_table #(
      .BINS_PER_HOUR(BINS_PER_HOUR)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   slot_schedule_checker #(
      .BINS_PER_HOUR(BINS_PER_HOUR)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count)
   );

   task automatic send_op(input int op, input int weekday, input int hour, input int minute,
                          input bit may_idle);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= OP_W'(op);
      req_tdata  <= REQ_DATA_W'({MINUTE_W'(minute), HOUR_W'(hour), DAY_W'(weekday)});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (may_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin : request_side
      int counted;
      int pick;
      int op;
      int wd;
      int hr;
      int mn;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_op(OP_FIND_NEXT, 0, 0, 0, 1'b1);
      send_op(OP_SET_DAY, 0, 0, 0, 1'b1);
      send_op(OP_FIND_NEXT, 0, 0, 0, 1'b1);
      send_op(OP_SET_DAY, LAST_DAY, LAST_HOUR, MAX_MINUTE, 1'b1);
      send_op(OP_FIND_NEXT, LAST_DAY, LAST_HOUR, MAX_MINUTE, 1'b1);
      send_op(OP_FIND_NEXT, 5, LAST_HOUR, 50, 1'b1);
      send_op(OP_SET_EVERY_DAY, 3, 12, 30, 1'b1);
      send_op(OP_FIND_NEXT, 1, 0, 0, 1'b1);
      send_op(OP_CLEAR_DAY, 1, 12, 30, 1'b1);
      send_op(OP_FIND_NEXT, 1, 0, 0, 1'b1);
      for (int d = 0; d <= LAST_DAY; d++) begin
         send_op(OP_SET_DAY, d, 8, 15, 1'b1);
      end
      send_op(OP_CLEAR_DAY, 2, 8, 15, 1'b1);
      send_op(OP_FIND_NEXT, 2, 8, 0, 1'b1);
      send_op(OP_SET_EVERY_DAY, DAY_CODE_MAX, HOUR_CODE_MAX, MINUTE_CODE_MAX, 1'b1);
      send_op(OP_FIND_NEXT, DAY_CODE_MAX, HOUR_CODE_MAX, MINUTE_CODE_MAX, 1'b1);
      send_op($urandom_range(OP_CLEAR_ALL + 1, OP_CODE_MAX), 0, 0, 0, 1'b1);
      send_op(OP_CLEAR_ALL, 0, 0, 0, 1'b1);
      send_op(OP_FIND_NEXT, 3, 10, 20, 1'b1);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 38) begin
            op = OP_SET_DAY;
         end else if (pick < 48) begin
            op = OP_SET_EVERY_DAY;
         end else if (pick < 63) begin
            op = OP_CLEAR_DAY;
         end else if (pick < 97) begin
            op = OP_FIND_NEXT;
         end else if (pick < 98) begin
            op = OP_CLEAR_ALL;
         end else begin
            op = $urandom_range(OP_CLEAR_ALL + 1, OP_CODE_MAX);
         end
         wd = $urandom_range(0, DAY_CODE_MAX);
         hr = ($urandom_range(0, 9) == 0) ? $urandom_range(HOURS_PER_DAY, HOUR_CODE_MAX)
                                          : $urandom_range(0, LAST_HOUR);
         mn = ($urandom_range(0, 9) == 0) ? $urandom_range(MINUTES_PER_HOUR, MINUTE_CODE_MAX)
                                          : $urandom_range(0, MAX_MINUTE);
         if (op <= OP_CLEAR_ALL) begin
            counted++;
         end
         if (counted == RANDOM_ITEMS - TAIL_ITEMS) begin
            quiet_tail <= 1'b1;
         end
         send_op(op, wd, hr, mn, counted < RANDOM_ITEMS - TAIL_ITEMS);
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("** weekly_slot_schedule_table: PASSED **");
      end else begin
         $display("** weekly_slot_schedule_table: FAILED **");
      end
      $finish;
   end

   initial begin : response_side
      int  span;
      int  elapsed;
      bit  held;
      elapsed = 0;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      while (!quiet_tail) begin
         if (!held && elapsed >= HOLD_START) begin
            rsp_tready <= 1'b0;
            for (span = 0; span < HOLD_CYCLES; span++) begin
               @(posedge clock);
            end
            held = 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            span = $urandom_range(1, 9);
            rsp_tready <= 1'b0;
            repeat (span) @(posedge clock);
         end else begin
            span = $urandom_range(1, 40);
            rsp_tready <= 1'b1;
            repeat (span) @(posedge clock);
         end
         elapsed += span;
      end
      rsp_tready <= 1'b1;
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** weekly_slot_schedule_table: FAILED **");
      $finish;
   end
endmodule
